### src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit: shared package
// Field widths, store geometry, codes, and the structs that pass between the
// console sequencer and the top level.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Store geometry: the screen store holds the largest screen in use.
  localparam int unsigned MAX_COLUMNS = 80;
  localparam int unsigned MAX_ROWS    = 25;
  localparam int unsigned STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_W      = $clog2(STORE_CELLS);

  // Field widths as they appear on the ports.
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CHR_W  = 8;
  localparam int unsigned CELL_W = 2 * CHR_W;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 2;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CHR_W-1:0]  chr_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Special characters.
  localparam chr_t CHAR_NEWLINE = 8'd10;
  localparam chr_t CHAR_SPACE   = 8'd32;

  // Function codes of an input transaction.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRINT = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } tcc_func_e;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_ATTR    = 2'd2
  } tcc_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_OP,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_CLEAR,
    ST_RESP
  } tcc_state_e;

  // Configuration as held by the top level.
  typedef struct packed {
    col_t columns;
    row_t rows;
    chr_t attr;
  } tcc_cfg_t;

  // One result transaction.
  typedef struct packed {
    col_t cursor_column;
    row_t cursor_row;
    chr_t cell_char;
    chr_t cell_attr;
  } tcc_res_t;

endpackage

### src/tcc_if.sv
// ----------------------------------------------------------------------------
// Text console channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  tcc_pkg::chr_t      char_code;
  tcc_pkg::col_t      read_column;
  tcc_pkg::row_t      read_row;

  modport source (output valid, func, char_code, read_column, read_row, input ready);
  modport sink   (input valid, func, char_code, read_column, read_row, output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  tcc_pkg::col_t      cursor_column;
  tcc_pkg::row_t      cursor_row;
  tcc_pkg::chr_t      cell_char;
  tcc_pkg::chr_t      cell_attr;

  modport source (output valid, cursor_column, cursor_row, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cell_char, cell_attr, output ready);
endinterface

### src/tcc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tcc_addr.sv
// ----------------------------------------------------------------------------
// Text console cell address unit
// Maps a (column, row) pair to a linear store index: row * width + column.
// ----------------------------------------------------------------------------
module tcc_addr (
  input  tcc_pkg::row_t  row_i,
  input  tcc_pkg::col_t  col_i,
  input  tcc_pkg::col_t  width_i,
  output tcc_pkg::addr_t addr_o
);

  localparam int unsigned SumW = tcc_pkg::ROW_W + tcc_pkg::COL_W + 1;

  logic [SumW-1:0] prod;
  logic [SumW-1:0] sum;

  // One small multiply and one add; the sum is cut to the store address width.
  always_comb begin
    prod = SumW'(row_i) * SumW'(width_i);
    sum  = prod + SumW'(col_i);
  end

  assign addr_o = sum[tcc_pkg::ADDR_W-1:0];

endmodule

### src/tcc_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Holds the cursor and walks the screen store through a single write port and
// a single read port for prints, reads, scrolls, clears and the reset pass.
// ----------------------------------------------------------------------------
module tcc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcc_pkg::tcc_cfg_t cfg_i,
  // Command side
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [1:0]        cmd_func_i,
  input  tcc_pkg::chr_t     cmd_char_i,
  input  tcc_pkg::col_t     cmd_col_i,
  input  tcc_pkg::row_t     cmd_row_i,
  // Result side
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tcc_pkg::tcc_res_t res_o
);

  tcc_pkg::tcc_state_e state_q, state_d;
  logic [1:0]          func_q;
  tcc_pkg::chr_t       char_q;
  tcc_pkg::col_t       rc_q;
  tcc_pkg::row_t       rr_q;
  tcc_pkg::col_t       cur_col_q, cur_col_d;
  tcc_pkg::row_t       cur_row_q, cur_row_d;
  tcc_pkg::addr_t      addr_q, addr_d;
  logic                rd_ok_q, rd_ok_d;
  tcc_pkg::addr_t      ptr_q, ptr_d;
  tcc_pkg::col_t       sc_q, sc_d;
  tcc_pkg::row_t       sr_q, sr_d;
  logic                copy_v_q, copy_v_d;
  tcc_pkg::addr_t      copy_a_q, copy_a_d;

  tcc_pkg::col_t       w_eff;
  tcc_pkg::row_t       h_eff;
  tcc_pkg::col_t       w_last;
  tcc_pkg::row_t       h_last;
  tcc_pkg::col_t       sat_col;
  tcc_pkg::row_t       sat_row;
  tcc_pkg::col_t       au_col;
  tcc_pkg::row_t       au_row;
  tcc_pkg::addr_t      au_addr;
  logic [tcc_pkg::COL_W:0] col_inc;
  logic [tcc_pkg::ROW_W:0] row_inc;
  logic                wrap;
  tcc_pkg::cell_t      blank;

  logic                ram_we;
  tcc_pkg::addr_t      ram_waddr;
  tcc_pkg::cell_t      ram_wdata;
  logic                ram_re;
  tcc_pkg::addr_t      ram_raddr;
  tcc_pkg::cell_t      ram_rdata;

  // Effective screen size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cfg_i.columns == '0) begin
      w_eff = tcc_pkg::col_t'(1);
    end else if (cfg_i.columns > tcc_pkg::col_t'(tcc_pkg::MAX_COLUMNS)) begin
      w_eff = tcc_pkg::col_t'(tcc_pkg::MAX_COLUMNS);
    end else begin
      w_eff = cfg_i.columns;
    end
    if (cfg_i.rows == '0) begin
      h_eff = tcc_pkg::row_t'(1);
    end else if (cfg_i.rows > tcc_pkg::row_t'(tcc_pkg::MAX_ROWS)) begin
      h_eff = tcc_pkg::row_t'(tcc_pkg::MAX_ROWS);
    end else begin
      h_eff = cfg_i.rows;
    end
    w_last = w_eff - tcc_pkg::col_t'(1);
    h_last = h_eff - tcc_pkg::row_t'(1);
  end

  // Cursor pulled back inside the screen, as a print sees it.
  always_comb begin
    sat_col = (cur_col_q >= w_eff) ? w_last : cur_col_q;
    sat_row = (cur_row_q >= h_eff) ? h_last : cur_row_q;
  end

  // The address unit serves the read position or the print position.
  always_comb begin
    if (func_q == tcc_pkg::FUNC_READ) begin
      au_col = rc_q;
      au_row = rr_q;
    end else begin
      au_col = sat_col;
      au_row = sat_row;
    end
  end

  tcc_addr u_addr (
    .row_i   (au_row),
    .col_i   (au_col),
    .width_i (w_eff),
    .addr_o  (au_addr)
  );

  // Cursor advance after a print; the cursor is already saturated here.
  always_comb begin
    col_inc = {1'b0, cur_col_q} + {{tcc_pkg::COL_W{1'b0}}, 1'b1};
    row_inc = {1'b0, cur_row_q} + {{tcc_pkg::ROW_W{1'b0}}, 1'b1};
    wrap    = (char_q == tcc_pkg::CHAR_NEWLINE) || (col_inc >= {1'b0, w_eff});
    blank   = {cfg_i.attr, tcc_pkg::CHAR_SPACE};
  end

  // Next state, store port control and counters.
  always_comb begin
    state_d   = state_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    addr_d    = addr_q;
    rd_ok_d   = rd_ok_q;
    ptr_d     = ptr_q;
    sc_d      = sc_q;
    sr_d      = sr_q;
    copy_v_d  = 1'b0;
    copy_a_d  = copy_a_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    // A scroll copy writes in the cycle after its read.
    if (copy_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = copy_a_q;
      ram_wdata = ram_rdata;
    end

    unique case (state_q)
      tcc_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = '0;
        ptr_d     = ptr_q + tcc_pkg::addr_t'(1);
        if (ptr_q == tcc_pkg::addr_t'(tcc_pkg::STORE_CELLS - 1)) begin
          ptr_d   = '0;
          state_d = tcc_pkg::ST_IDLE;
        end
      end

      tcc_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          state_d = tcc_pkg::ST_ADDR;
        end
      end

      tcc_pkg::ST_ADDR: begin
        addr_d  = au_addr;
        rd_ok_d = (rc_q < w_eff) && (rr_q < h_eff);
        unique case (func_q)
          tcc_pkg::FUNC_PRINT: begin
            cur_col_d = sat_col;
            cur_row_d = sat_row;
            state_d   = tcc_pkg::ST_OP;
          end
          tcc_pkg::FUNC_READ: begin
            state_d = tcc_pkg::ST_OP;
          end
          tcc_pkg::FUNC_CLEAR: begin
            ptr_d   = '0;
            sc_d    = '0;
            sr_d    = '0;
            state_d = tcc_pkg::ST_CLEAR;
          end
          default: begin
            state_d = tcc_pkg::ST_RESP;
          end
        endcase
      end

      tcc_pkg::ST_OP: begin
        if (func_q == tcc_pkg::FUNC_READ) begin
          ram_re    = rd_ok_q;
          ram_raddr = addr_q;
          state_d   = tcc_pkg::ST_RESP;
        end else begin
          if (char_q != tcc_pkg::CHAR_NEWLINE) begin
            ram_we    = 1'b1;
            ram_waddr = addr_q;
            ram_wdata = {cfg_i.attr, char_q};
          end
          cur_col_d = wrap ? '0 : col_inc[tcc_pkg::COL_W-1:0];
          if (wrap && (row_inc >= {1'b0, h_eff})) begin
            // Passed the last row: scroll up and blank the bottom row.
            cur_col_d = '0;
            cur_row_d = h_last;
            sc_d      = '0;
            if (h_eff == tcc_pkg::row_t'(1)) begin
              ptr_d   = '0;
              state_d = tcc_pkg::ST_BLANK;
            end else begin
              ptr_d   = tcc_pkg::addr_t'(w_eff);
              sr_d    = tcc_pkg::row_t'(1);
              state_d = tcc_pkg::ST_COPY;
            end
          end else begin
            if (wrap) begin
              cur_row_d = row_inc[tcc_pkg::ROW_W-1:0];
            end
            state_d = tcc_pkg::ST_RESP;
          end
        end
      end

      tcc_pkg::ST_COPY: begin
        // Read each cell of rows one and up; it lands one row higher.
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        copy_v_d  = 1'b1;
        copy_a_d  = ptr_q - tcc_pkg::addr_t'(w_eff);
        ptr_d     = ptr_q + tcc_pkg::addr_t'(1);
        if (sc_q == w_last) begin
          sc_d = '0;
          if (sr_q == h_last) begin
            state_d = tcc_pkg::ST_DRAIN;
          end else begin
            sr_d = sr_q + tcc_pkg::row_t'(1);
          end
        end else begin
          sc_d = sc_q + tcc_pkg::col_t'(1);
        end
      end

      tcc_pkg::ST_DRAIN: begin
        // The last copy write goes out here; the bottom row starts next.
        ptr_d   = ptr_q - tcc_pkg::addr_t'(w_eff);
        sc_d    = '0;
        state_d = tcc_pkg::ST_BLANK;
      end

      tcc_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = blank;
        ptr_d     = ptr_q + tcc_pkg::addr_t'(1);
        if (sc_q == w_last) begin
          state_d = tcc_pkg::ST_RESP;
        end else begin
          sc_d = sc_q + tcc_pkg::col_t'(1);
        end
      end

      tcc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = blank;
        ptr_d     = ptr_q + tcc_pkg::addr_t'(1);
        if (sc_q == w_last) begin
          sc_d = '0;
          if (sr_q == h_last) begin
            cur_col_d = '0;
            cur_row_d = '0;
            state_d   = tcc_pkg::ST_RESP;
          end else begin
            sr_d = sr_q + tcc_pkg::row_t'(1);
          end
        end else begin
          sc_d = sc_q + tcc_pkg::col_t'(1);
        end
      end

      tcc_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tcc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcc_pkg::ST_IDLE;
      end
    endcase
  end

  // Result payload; cell fields come from the store only for a valid read.
  always_comb begin
    res_o.cursor_column = cur_col_q;
    res_o.cursor_row    = cur_row_q;
    if ((func_q == tcc_pkg::FUNC_READ) && rd_ok_q) begin
      res_o.cell_char = ram_rdata[tcc_pkg::CHR_W-1:0];
      res_o.cell_attr = ram_rdata[tcc_pkg::CELL_W-1:tcc_pkg::CHR_W];
    end else begin
      res_o.cell_char = '0;
      res_o.cell_attr = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcc_pkg::ST_INIT;
      cur_col_q <= '0;
      cur_row_q <= '0;
      ptr_q     <= '0;
      sc_q      <= '0;
      sr_q      <= '0;
      copy_v_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      ptr_q     <= ptr_d;
      sc_q      <= sc_d;
      sr_q      <= sr_d;
      copy_v_q  <= copy_v_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // Command capture and working addresses.
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      func_q <= cmd_func_i;
      char_q <= cmd_char_i;
      rc_q   <= cmd_col_i;
      rr_q   <= cmd_row_i;
    end
    addr_q   <= addr_d;
    copy_a_q <= copy_a_d;
  end

  tcc_ram #(
    .WIDTH (tcc_pkg::CELL_W),
    .DEPTH (tcc_pkg::STORE_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### src/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit
// Character screen store with cursor handling, scrolling, clear and read-back.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time. A print or a read goes through
// the address and operation states to the result; a print that passes the
// last row adds a scroll (on a one-row screen only a blank of that row), and
// a clear blanks every cell of an effective screen of w columns and h rows.
// As the store has one write port and one read port, a scroll or a clear
// moves one cell per cycle. After reset the store is swept to zero before the
// first command is taken. Configuration writes are taken at any time, but
// should only be made while no command is in progress. A finished result
// sits in an output register, so the next command is accepted while it
// waits to be taken.
module text_console_cursor_scroll_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tcc_in_if.sink                      cmd_i,
  tcc_out_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [tcc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  tcc_pkg::chr_t               cfg_data_i
);

  tcc_pkg::tcc_cfg_t cfg_q;
  tcc_pkg::tcc_res_t seq_res;
  logic              seq_res_valid;
  logic              seq_res_ready;
  logic              out_valid_q;
  tcc_pkg::tcc_res_t out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= tcc_pkg::col_t'(80);
      cfg_q.rows    <= tcc_pkg::row_t'(25);
      cfg_q.attr    <= tcc_pkg::chr_t'(7);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcc_pkg::REG_COLUMNS: cfg_q.columns <= cfg_data_i[tcc_pkg::COL_W-1:0];
        tcc_pkg::REG_ROWS:    cfg_q.rows    <= cfg_data_i[tcc_pkg::ROW_W-1:0];
        tcc_pkg::REG_ATTR:    cfg_q.attr    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_func_i  (cmd_i.func),
    .cmd_char_i  (cmd_i.char_code),
    .cmd_col_i   (cmd_i.read_column),
    .cmd_row_i   (cmd_i.read_row),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res)
  );

  // Output register: takes a new result when empty or being drained.
  assign seq_res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_q <= seq_res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.cursor_column = out_q.cursor_column;
  assign res_o.cursor_row    = out_q.cursor_row;
  assign res_o.cell_char     = out_q.cell_char;
  assign res_o.cell_attr     = out_q.cell_attr;

endmodule

### src/tcc_checker.sv
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the command and result channels of the console unit over time.
// ----------------------------------------------------------------------------
module tcc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cmd_valid_i,
  input logic          cmd_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input tcc_pkg::col_t res_col_i,
  input tcc_pkg::row_t res_row_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result transaction withdrawn before it was taken");

  // A stalled result keeps its cursor fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_col_i) && $stable(res_row_i))
    else $error("stalled result changed its cursor");

  // Commands are worked one at a time: no command right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while the previous one is in progress");

  // The reported cursor always lies inside the largest screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_col_i < tcc_pkg::col_t'(tcc_pkg::MAX_COLUMNS)) &&
                    (res_row_i < tcc_pkg::row_t'(tcc_pkg::MAX_ROWS)))
    else $error("reported cursor outside the screen store");

endmodule

bind text_console_cursor_scroll_unit tcc_checker u_tcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_col_i   (res_o.cursor_column),
  .res_row_i   (res_o.cursor_row)
);
